// ===== rtl/vms_pkg.sv =====
// ----------------------------------------------------------------------------
// vms_pkg
// Shared types and constants of the voltage/current sample conditioner.
// ----------------------------------------------------------------------------
package vms_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REF_OFFSET      = 3'd0,
    CFG_VOLTAGE_GAIN    = 3'd1,
    CFG_CURRENT_GAIN    = 3'd2,
    CFG_ZERO_THRESHOLD  = 3'd3,
    CFG_TARE_HOLD_COUNT = 3'd4
  } cfg_idx_t;

  // register widths and reset values
  localparam int REF_W   = 10;
  localparam int GAIN_W  = 16;
  localparam int THR_W   = 10;
  localparam int HOLD_W  = 8;

  localparam logic [REF_W-1:0]  REF_OFFSET_RST      = 10'd612;
  localparam logic [GAIN_W-1:0] VOLTAGE_GAIN_RST    = 16'd34816;
  localparam logic [GAIN_W-1:0] CURRENT_GAIN_RST    = 16'd5535;
  localparam logic [THR_W-1:0]  ZERO_THRESHOLD_RST  = 10'd100;
  localparam logic [HOLD_W-1:0] TARE_HOLD_COUNT_RST = 8'd100;

  // result fields
  localparam int VMV_W  = 18;
  localparam int CMA_W  = 15;
  localparam int TARE_W = 16;

  localparam logic [VMV_W-1:0] VMV_MAX        = 18'h3ffff;
  localparam logic [CMA_W-1:0] CMA_MAX        = 15'h7fff;
  localparam logic [VMV_W-1:0] VOLTAGE_HOLD_RST = 18'd1500;
  localparam logic [CMA_W-1:0] CURRENT_HOLD_RST = 15'd15500;

  // gains are unsigned Q8
  localparam int GAIN_FRAC = 8;

  // exponential averages: avg = (MUL*avg + sample) / DIV
  localparam int REM_W = 6;
  localparam logic [REM_W-1:0] VOLT_DIV = 6'd10;
  localparam logic [REM_W-1:0] CURR_DIV = 6'd50;
  localparam int VOLT_MUL = 9;
  localparam int CURR_MUL = 49;

  // numerator bits taken per reciprocal multiply cycle
  localparam int RCP_CHUNK = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic mul;
    logic fin;
  } cmd_t;

endpackage

// ===== rtl/vms_if.sv =====
// ----------------------------------------------------------------------------
// vms_if
// Valid/ready channels of the sample conditioner: samples, results, config.
// ----------------------------------------------------------------------------
interface vms_in_if #(
  parameter int SAMPLE_BITS = 10
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   switch_pressed;

  modport source (output valid, sample, switch_pressed, input ready);
  modport sink   (input valid, sample, switch_pressed, output ready);
endinterface

interface vms_out_if ();
  logic                       valid;
  logic                       ready;
  logic [vms_pkg::VMV_W-1:0]  voltage_mv;
  logic [vms_pkg::CMA_W-1:0]  current_ma;
  logic                       sampled_channel;
  logic                       tare_taken;

  modport source (output valid, voltage_mv, current_ma, sampled_channel, tare_taken,
                  input ready);
  modport sink   (input valid, voltage_mv, current_ma, sampled_channel, tare_taken,
                  output ready);
endinterface

interface vms_cfg_if ();
  logic                          valid;
  logic                          ready;
  logic [vms_pkg::CFG_IDX_W-1:0]  index;
  logic [vms_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/vms_ctrl.sv =====
// ----------------------------------------------------------------------------
// vms_ctrl
// Sequencer: accept, divider steps, gain multiply, finish, result handoff.
// ----------------------------------------------------------------------------
module vms_ctrl #(
  parameter int NUM_STEPS = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output vms_pkg::cmd_t cmd
);

  localparam int CNT_W = (NUM_STEPS > 1) ? $clog2(NUM_STEPS) : 1;

  vms_pkg::state_t  state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vms_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      vms_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = vms_pkg::ST_DIV;
        end
      end
      vms_pkg::ST_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_STEPS - 1)) begin
          state_nxt = vms_pkg::ST_MUL;
        end
      end
      vms_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = vms_pkg::ST_FIN;
      end
      vms_pkg::ST_FIN: begin
        // wait for the result slot to drain
        if (!out_valid_r || out_ready) begin
          cmd.fin   = 1'b1;
          state_nxt = vms_pkg::ST_IDLE;
        end
      end
      default: state_nxt = vms_pkg::ST_IDLE;
    endcase
    out_valid_nxt = (out_valid_r && !out_ready) || cmd.fin;
  end

  assign out_valid = out_valid_r;

  a_load_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == vms_pkg::ST_DIV))
    else $error("accepted sample did not start the divider");

  a_fin_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |-> (!out_valid_r || out_ready))
    else $error("result overwritten before transfer");

  a_valid_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.fin))
    else $error("result valid without finish");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == vms_pkg::ST_DIV) |-> (cnt_r <= CNT_W'(NUM_STEPS - 1)))
    else $error("divider step count out of range");

endmodule

// ===== rtl/vms_datapath.sv =====
// ----------------------------------------------------------------------------
// vms_datapath
// Averages, reciprocal divide, gain multiply, tare and saturation, config regs.
// ----------------------------------------------------------------------------
module vms_datapath #(
  parameter int SAMPLE_BITS = 10,
  parameter int FRAC_BITS   = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  vms_pkg::cmd_t                   cmd,
  input  logic [SAMPLE_BITS-1:0]          in_sample,
  input  logic                            in_switch_pressed,
  input  logic                            cfg_we,
  input  logic [vms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vms_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic [vms_pkg::VMV_W-1:0]       out_voltage_mv,
  output logic [vms_pkg::CMA_W-1:0]       out_current_ma,
  output logic                            out_sampled_channel,
  output logic                            out_tare_taken
);

  localparam int AVG_W  = SAMPLE_BITS + FRAC_BITS;
  localparam int NW     = AVG_W + vms_pkg::REM_W;
  localparam int CH     = vms_pkg::RCP_CHUNK;
  localparam int NSTEP  = (NW + CH - 1) / CH;
  localparam int NPW    = NSTEP * CH;
  localparam int RK     = NW + vms_pkg::REM_W;
  localparam int RKW    = RK + 1;
  localparam int RCW    = RK - 3;
  localparam int ACW    = NW + RCW;
  localparam int PRTW   = RCW + CH;
  localparam int REFQ_W = vms_pkg::REF_W + FRAC_BITS;
  localparam int MW     = (AVG_W > REFQ_W) ? AVG_W : REFQ_W;
  localparam int PW     = MW + vms_pkg::GAIN_W;
  localparam int SH     = FRAC_BITS + vms_pkg::GAIN_FRAC;
  localparam int RW     = PW + 1;
  localparam int CW     = RW + 1;

  // ceil(2^RK / div), exact floor for any numerator below 2^NW
  localparam logic [RKW-1:0] RCP_ONE  = RKW'(1) << RK;
  localparam logic [RCW-1:0] VOLT_RCP =
    RCW'((RCP_ONE + RKW'(vms_pkg::VOLT_DIV) - RKW'(1)) / RKW'(vms_pkg::VOLT_DIV));
  localparam logic [RCW-1:0] CURR_RCP =
    RCW'((RCP_ONE + RKW'(vms_pkg::CURR_DIV) - RKW'(1)) / RKW'(vms_pkg::CURR_DIV));

  // configuration
  logic [vms_pkg::REF_W-1:0]  ref_offset_r;
  logic [vms_pkg::GAIN_W-1:0] voltage_gain_r;
  logic [vms_pkg::GAIN_W-1:0] current_gain_r;
  logic [vms_pkg::THR_W-1:0]  zero_threshold_r;
  logic [vms_pkg::HOLD_W-1:0] tare_hold_r;

  // block state
  logic [AVG_W-1:0]            volt_avg_r;
  logic [AVG_W-1:0]            curr_avg_r;
  logic [vms_pkg::TARE_W-1:0]  tare_r, tare_nxt;
  logic [vms_pkg::HOLD_W-1:0]  press_cnt_r, press_cnt_nxt;
  logic                        next_chan_r;
  logic [vms_pkg::VMV_W-1:0]   volt_hold_r, volt_hold_nxt;
  logic [vms_pkg::CMA_W-1:0]   curr_hold_r, curr_hold_nxt;

  // working registers
  logic                        chan_r;
  logic                        pressed_r;
  logic [NPW-1:0]              num_r;
  logic [ACW-1:0]              acc_r, acc_nxt;
  logic [PW-1:0]               prod_r, prod_nxt;
  logic                        neg_r, neg_nxt;
  logic                        out_chan_r;
  logic                        out_taken_r;
  logic                        taken;

  logic [AVG_W-1:0]            avg_sel;
  logic [NW-1:0]               avg_x;
  logic [NW-1:0]               dividend;
  logic [RCW-1:0]              rcp;
  logic [CH-1:0]               chunk;
  logic [PRTW-1:0]             part;
  logic [AVG_W-1:0]            quot;
  logic [MW-1:0]               quot_m;
  logic [MW-1:0]               ref_q;
  logic [MW-1:0]               mag;

  logic [PW-1:0]               scaled;
  logic signed [RW-1:0]        scaled_s;
  logic signed [RW-1:0]        reading;
  logic signed [CW-1:0]        diff;
  logic signed [CW-1:0]        thr_s;
  logic [vms_pkg::HOLD_W-1:0]  press_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_offset_r     <= vms_pkg::REF_OFFSET_RST;
      voltage_gain_r   <= vms_pkg::VOLTAGE_GAIN_RST;
      current_gain_r   <= vms_pkg::CURRENT_GAIN_RST;
      zero_threshold_r <= vms_pkg::ZERO_THRESHOLD_RST;
      tare_hold_r      <= vms_pkg::TARE_HOLD_COUNT_RST;
    end else if (cfg_we) begin
      unique case (vms_pkg::cfg_idx_t'(cfg_index))
        vms_pkg::CFG_REF_OFFSET:      ref_offset_r     <= cfg_data[vms_pkg::REF_W-1:0];
        vms_pkg::CFG_VOLTAGE_GAIN:    voltage_gain_r   <= cfg_data;
        vms_pkg::CFG_CURRENT_GAIN:    current_gain_r   <= cfg_data;
        vms_pkg::CFG_ZERO_THRESHOLD:  zero_threshold_r <= cfg_data[vms_pkg::THR_W-1:0];
        vms_pkg::CFG_TARE_HOLD_COUNT: tare_hold_r      <= cfg_data[vms_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // new average numerator
  always_comb begin
    avg_sel = next_chan_r ? curr_avg_r : volt_avg_r;
    if (next_chan_r) begin
      avg_x = (NW'(avg_sel) << 5) + (NW'(avg_sel) << 4) + NW'(avg_sel);
    end else begin
      avg_x = (NW'(avg_sel) << 3) + NW'(avg_sel);
    end
    dividend = avg_x + (NW'(in_sample) << FRAC_BITS);
  end

  // divide by 10 or 50 as a multiply by the reciprocal, numerator msb chunk first
  always_comb begin
    rcp     = chan_r ? CURR_RCP : VOLT_RCP;
    chunk   = num_r[NPW-1 -: CH];
    part    = PRTW'(rcp) * PRTW'(chunk);
    acc_nxt = (acc_r << CH) + ACW'(part);
  end

  // offset removal (current channel only) and gain
  always_comb begin
    quot   = acc_r[RK +: AVG_W];
    quot_m = MW'(quot);
    ref_q  = MW'(ref_offset_r) << FRAC_BITS;
    if (chan_r) begin
      neg_nxt  = quot_m < ref_q;
      mag      = neg_nxt ? (ref_q - quot_m) : (quot_m - ref_q);
      prod_nxt = PW'(mag) * PW'(current_gain_r);
    end else begin
      neg_nxt  = 1'b0;
      mag      = quot_m;
      prod_nxt = PW'(mag) * PW'(voltage_gain_r);
    end
  end

  // finish: saturation, tare, zero clamp
  always_comb begin
    scaled   = prod_r >> SH;
    scaled_s = signed'({1'b0, scaled});
    reading  = neg_r ? (RW'(0) - scaled_s) : scaled_s;

    volt_hold_nxt = volt_hold_r;
    curr_hold_nxt = curr_hold_r;
    tare_nxt      = tare_r;
    press_cnt_nxt = press_cnt_r;
    taken         = 1'b0;
    press_inc     = pressed_r ? (press_cnt_r + 1'b1) : '0;
    diff          = '0;
    thr_s         = signed'(CW'(zero_threshold_r));

    if (!chan_r) begin
      if (scaled > PW'(vms_pkg::VMV_MAX)) begin
        volt_hold_nxt = vms_pkg::VMV_MAX;
      end else begin
        volt_hold_nxt = scaled[vms_pkg::VMV_W-1:0];
      end
    end else begin
      press_cnt_nxt = press_inc;
      if (press_inc >= tare_hold_r) begin
        press_cnt_nxt = '0;
        taken         = 1'b1;
        if (reading > signed'({{(RW-vms_pkg::TARE_W){1'b0}}, 16'h7fff})) begin
          tare_nxt = 16'h7fff;
        end else if (reading < signed'({{(RW-vms_pkg::TARE_W){1'b1}}, 16'h8000})) begin
          tare_nxt = 16'h8000;
        end else begin
          tare_nxt = reading[vms_pkg::TARE_W-1:0];
        end
      end
      diff = CW'(reading) - CW'(signed'(tare_nxt));
      if (diff <= thr_s) begin
        curr_hold_nxt = '0;
      end else if (diff > signed'(CW'(vms_pkg::CMA_MAX))) begin
        curr_hold_nxt = vms_pkg::CMA_MAX;
      end else begin
        curr_hold_nxt = diff[vms_pkg::CMA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volt_avg_r  <= '0;
      curr_avg_r  <= '0;
      tare_r      <= '0;
      press_cnt_r <= '0;
      next_chan_r <= 1'b0;
      volt_hold_r <= vms_pkg::VOLTAGE_HOLD_RST;
      curr_hold_r <= vms_pkg::CURRENT_HOLD_RST;
    end else begin
      if (cmd.mul) begin
        if (chan_r) begin
          curr_avg_r <= quot;
        end else begin
          volt_avg_r <= quot;
        end
      end
      if (cmd.fin) begin
        tare_r      <= tare_nxt;
        press_cnt_r <= press_cnt_nxt;
        next_chan_r <= ~chan_r;
        volt_hold_r <= volt_hold_nxt;
        curr_hold_r <= curr_hold_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      chan_r    <= next_chan_r;
      pressed_r <= in_switch_pressed;
      num_r     <= NPW'(dividend);
      acc_r     <= '0;
    end else if (cmd.step) begin
      num_r <= num_r << CH;
      acc_r <= acc_nxt;
    end
    if (cmd.mul) begin
      prod_r <= prod_nxt;
      neg_r  <= neg_nxt;
    end
    if (cmd.fin) begin
      out_chan_r  <= chan_r;
      out_taken_r <= taken;
    end
  end

  assign out_voltage_mv      = volt_hold_r;
  assign out_current_ma      = curr_hold_r;
  assign out_sampled_channel = out_chan_r;
  assign out_tare_taken      = out_taken_r;

endmodule

// ===== rtl/vi_meter_sample_conditioner.sv =====
// ----------------------------------------------------------------------------
// vi_meter_sample_conditioner
// Smooths alternating voltage/current ADC samples, scales, tares and clamps.
// ----------------------------------------------------------------------------
//  channel    dir  payload                                          transfer
//  in_port    in   sample, switch_pressed                           valid & ready
//  out_port   out  voltage_mv, current_ma, sampled_channel, tare_taken  valid & ready
//  cfg_port   in   index, data                                      valid & ready
//
//  one sample at a time, in order: the accept, the reciprocal multiply steps
//  (one per 16-bit chunk of the SAMPLE_BITS+FRAC_BITS+6 bit numerator), the
//  gain multiply and the finish
//  the division of the average by 10 or 50, done as a chunked multiply by the
//  reciprocal, sets the sample period
//  the result register holds while out_port stalls; the next sample is taken
//  meanwhile and waits in its finish cycle until the result transfers
//  synchronous active-low reset; config writes are taken in every cycle
// ----------------------------------------------------------------------------
module vi_meter_sample_conditioner #(
  parameter int SAMPLE_BITS = 10,
  parameter int FRAC_BITS   = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  vms_in_if.sink      in_port,
  vms_out_if.source   out_port,
  vms_cfg_if.sink     cfg_port
);

  localparam int AVG_W = SAMPLE_BITS + FRAC_BITS;
  localparam int NW    = AVG_W + vms_pkg::REM_W;
  localparam int NSTEP = (NW + vms_pkg::RCP_CHUNK - 1) / vms_pkg::RCP_CHUNK;

  vms_pkg::cmd_t cmd;

  assign cfg_port.ready = 1'b1;

  vms_ctrl #(
    .NUM_STEPS (NSTEP)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_port.valid),
    .in_ready  (in_port.ready),
    .out_valid (out_port.valid),
    .out_ready (out_port.ready),
    .cmd       (cmd)
  );

  vms_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_sample           (in_port.sample),
    .in_switch_pressed   (in_port.switch_pressed),
    .cfg_we              (cfg_port.valid),
    .cfg_index           (cfg_port.index),
    .cfg_data            (cfg_port.data),
    .out_voltage_mv      (out_port.voltage_mv),
    .out_current_ma      (out_port.current_ma),
    .out_sampled_channel (out_port.sampled_channel),
    .out_tare_taken      (out_port.tare_taken)
  );

endmodule
